>>> src/gll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gll_pkg;

	// One operand pair, as moved by a single request transfer.
	typedef struct packed {
		logic [15:0] first_number;
		logic [15:0] second_number;
	} gll_req_t;

	// One result, as moved by a single result transfer.
	typedef struct packed {
		logic [15:0] gcd_value;
		logic [31:0] lcm_value;
		logic        lcm_fits_16;
	} gll_res_t;

	// Operation of the shared adder/subtractor.
	typedef enum logic {
		OP_ADD,
		OP_SUB
	} gll_op_t;

	// Sequencer phases.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_MUL
	} gll_state_t;

endpackage

`default_nettype wire

>>> src/gcd_lcm_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Greatest common divisor and least common multiple of two unsigned numbers.
//
// A request transfer takes place at a rising edge with start high and busy low;
// the pair on request is captured then. Only the low OPERAND_WIDTH bits of each
// operand take part. Each request produces exactly one result, shown on result
// for a single cycle while done is high; the receiver cannot stall it, so it
// must take the result transfer in that cycle.
//
// If either operand is zero, done rises on the very next cycle with the other
// operand as divisor and a multiple of zero. Otherwise one adder/subtractor is
// reused by a small sequencer: a binary gcd phase (one shift, compare-and-swap
// or subtraction per step), a step that spots the end of the gcd, a restoring
// division of the first operand by the divisor and a shift-add multiplication
// by the second operand. busy is high throughout.
//
// Reset clears the sequencer and the done strobe; the block keeps no state from
// one pair to the next.

module gcd_lcm_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gll_pkg::gll_req_t request,
	output logic              busy,
	output logic              done,
	output gll_pkg::gll_res_t result
);
	import gll_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int AW = W + 1;
	localparam int CW = $clog2(W);

	gll_state_t     state_q, state_d;
	logic           done_q, done_d;
	logic [W-1:0]   a_q, a_d, b_q, b_d;
	logic [W-1:0]   x_q, x_d, y_q, y_d;
	logic [CW-1:0]  k_q, k_d;
	logic [W-1:0]   g_q, g_d;
	logic [W-1:0]   rem_q, rem_d;
	logic [W-1:0]   quo_q, quo_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	gll_res_t       res_q, res_d;

	logic [31:0]    ext_a, ext_b, zero_gcd, ext_gcd;
	logic [W-1:0]   op_a, op_b;
	logic [AW-1:0]  alu_x, alu_y;
	gll_op_t        alu_op;
	logic [AW:0]    alu_sum;
	logic [AW-1:0]  shifted;
	logic [2*W-1:0] prod;
	logic [63:0]    prod64;

	// Operands are cut to the working width, or zero-extended when it is wider.
	assign ext_a    = 32'(request.first_number);
	assign ext_b    = 32'(request.second_number);
	assign op_a     = ext_a[W-1:0];
	assign op_b     = ext_b[W-1:0];
	assign zero_gcd = 32'(op_a | op_b);
	assign ext_gcd  = 32'(g_q);

	// Partial remainder with the next dividend bit brought in.
	assign shifted  = {rem_q, quo_q[W-1]};

	// Full product as it stands after the current multiply step.
	assign prod     = {alu_sum[W:0], quo_q[W-1:1]};
	assign prod64   = 64'(prod);

	gll_addsub #(
		.WIDTH(AW)
	) u_addsub (
		.x   (alu_x),
		.y   (alu_y),
		.op  (alu_op),
		.sum (alu_sum)
	);

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		a_d     = a_q;
		b_d     = b_q;
		x_d     = x_q;
		y_d     = y_q;
		k_d     = k_q;
		g_d     = g_q;
		rem_d   = rem_q;
		quo_d   = quo_q;
		cnt_d   = cnt_q;
		res_d   = res_q;
		alu_op  = OP_SUB;
		alu_x   = {1'b0, x_q};
		alu_y   = {1'b0, y_q};

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					a_d = op_a;
					b_d = op_b;
					x_d = op_a;
					y_d = op_b;
					k_d = '0;
					if (op_a == '0 || op_b == '0) begin
						res_d.gcd_value   = zero_gcd[15:0];
						res_d.lcm_value   = '0;
						res_d.lcm_fits_16 = 1'b1;
						done_d            = 1'b1;
					end else begin
						state_d = ST_GCD;
					end
				end
			end

			ST_GCD: begin
				// Binary gcd: common factors of two are counted in k and put back at the end.
				if (x_q == '0) begin
					g_d     = y_q << k_q;
					rem_d   = '0;
					quo_d   = a_q;
					cnt_d   = CW'(W - 1);
					state_d = ST_DIV;
				end else if (!x_q[0] && !y_q[0]) begin
					x_d = x_q >> 1;
					y_d = y_q >> 1;
					k_d = k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_d = x_q >> 1;
				end else if (!y_q[0]) begin
					y_d = y_q >> 1;
				end else if (!alu_sum[AW]) begin
					// Both odd and x below y: swap so that the next subtraction is positive.
					x_d = y_q;
					y_d = x_q;
				end else begin
					x_d = alu_sum[W-1:0];
				end
			end

			ST_DIV: begin
				alu_x = shifted;
				alu_y = {1'b0, g_q};
				rem_d = alu_sum[AW] ? alu_sum[W-1:0] : shifted[W-1:0];
				quo_d = {quo_q[W-2:0], alu_sum[AW]};
				if (cnt_q == '0) begin
					// The division is exact, so the remainder is dropped and becomes
					// the cleared upper half of the product.
					rem_d   = '0;
					cnt_d   = CW'(W - 1);
					state_d = ST_MUL;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end

			ST_MUL: begin
				alu_op = OP_ADD;
				alu_x  = {1'b0, rem_q};
				alu_y  = quo_q[0] ? {1'b0, b_q} : '0;
				rem_d  = alu_sum[W:1];
				quo_d  = {alu_sum[0], quo_q[W-1:1]};
				if (cnt_q == '0) begin
					res_d.gcd_value   = ext_gcd[15:0];
					res_d.lcm_value   = (prod64[63:32] != '0) ? '1 : prod64[31:0];
					res_d.lcm_fits_16 = ((prod64 >> W) == '0);
					done_d            = 1'b1;
					state_d           = ST_IDLE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q   <= a_d;
		b_q   <= b_d;
		x_q   <= x_d;
		y_q   <= y_d;
		k_q   <= k_d;
		g_q   <= g_d;
		rem_q <= rem_d;
		quo_q <= quo_d;
		cnt_q <= cnt_d;
		res_q <= res_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

>>> src/gll_addsub.sv
`timescale 1ns / 1ps
`default_nettype none

module gll_addsub #(
	parameter int WIDTH = 17
) (
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	input  gll_pkg::gll_op_t op,
	output logic [WIDTH:0]   sum
);
	import gll_pkg::*;

	logic             sub;
	logic [WIDTH-1:0] y_inv;

	// The top bit is the carry out; on subtraction it is set when x >= y.
	assign sub   = (op == OP_SUB);
	assign y_inv = y ^ {WIDTH{sub}};
	assign sum   = {1'b0, x} + {1'b0, y_inv} + {{WIDTH{1'b0}}, sub};

endmodule

`default_nettype wire

>>> tb/sv/tb_gcd_lcm_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for gcd_lcm_unit. Operand pairs go in over the start/busy
// handshake, and every pair accepted by the block is passed to a scoreboard.
// The scoreboard works out the divisor, the full-width multiple and the fit flag
// on its own and queues them. Each result strobed out on done is then compared,
// field by field, against the oldest queued expectation. The block cannot stall
// its results, so the bench only varies the gaps between request transfers.
module tb_gcd_lcm_unit;
	import gll_pkg::*;

	// Scoreboard: holds the results still owed by the block and checks the
	// result transfers against them in order.
	class gcd_lcm_board;
		gll_res_t expected_results[$];
		int       pairs_noted;
		int       results_checked;
		int       mismatch_count;
		int       stray_count;
		int       zero_pairs;
		int       wide_multiples;

		function new();
			pairs_noted     = 0;
			results_checked = 0;
			mismatch_count  = 0;
			stray_count     = 0;
			zero_pairs      = 0;
			wide_multiples  = 0;
		endfunction

		// Euclid on the operands, then the multiple as (a / gcd) * b, which
		// always fits 32 bits at this operand width.
		function gll_res_t gcd_lcm_of(gll_req_t pair);
			logic [15:0] a;
			logic [15:0] b;
			logic [15:0] x;
			logic [15:0] y;
			logic [15:0] r;
			logic [31:0] quotient;
			logic [31:0] multiple;
			gll_res_t    res;
			a = pair.first_number;
			b = pair.second_number;
			x = a;
			y = b;
			while (y != 16'd0) begin
				r = x % y;
				x = y;
				y = r;
			end
			multiple = 32'd0;
			if (a != 16'd0 && b != 16'd0) begin
				quotient = {16'd0, a / x};
				multiple = quotient * {16'd0, b};
			end
			res.gcd_value   = x;
			res.lcm_value   = multiple;
			res.lcm_fits_16 = (multiple <= 32'h0000_FFFF);
			return res;
		endfunction

		function void note_pair(gll_req_t pair);
			gll_res_t res;
			res = gcd_lcm_of(pair);
			expected_results.push_back(res);
			pairs_noted++;
			if (pair.first_number == 16'd0 || pair.second_number == 16'd0)
				zero_pairs++;
			if (!res.lcm_fits_16)
				wide_multiples++;
		endfunction

		function void check_result(gll_res_t got);
			gll_res_t want;
			bit       bad;
			if (expected_results.size() == 0) begin
				stray_count++;
				$display("[%0t] result with nothing outstanding: gcd %0d lcm %0d fits %0b",
					$realtime, got.gcd_value, got.lcm_value, got.lcm_fits_16);
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			bad = 1'b0;
			if (got.gcd_value !== want.gcd_value)
				bad = 1'b1;
			if (got.lcm_value !== want.lcm_value)
				bad = 1'b1;
			if (got.lcm_fits_16 !== want.lcm_fits_16)
				bad = 1'b1;
			if (bad) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("[%0t] mismatch: expected gcd %0d lcm %0d fits %0b, got gcd %0d lcm %0d fits %0b",
						$realtime, want.gcd_value, want.lcm_value, want.lcm_fits_16,
						got.gcd_value, got.lcm_value, got.lcm_fits_16);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	gll_req_t request;
	logic     busy;
	logic     done;
	gll_res_t result;

	gcd_lcm_board board;
	int           items_sent;

	gcd_lcm_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog. The slowest legal run is roughly 2000 pairs, each with its
	// computation and the longest gap between requests; ten milliseconds leaves
	// ample margin.
	initial begin
		#10ms;
		$display("Timeout with %0d results outstanding", board.pending());
		$display("Some tests failed");
		$finish;
	end

	// Monitor. Both transfers are observed at the rising edge, where start and
	// request are stable (they only move on the falling edge) and busy and done
	// still hold the values of the cycle just ending. A request transfer always
	// comes in an earlier cycle than its own result, so the order of the two
	// checks within one edge does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_pair(request);
			if (done)
				board.check_result(result);
		end
	end

	// Idle time before the next request. Mostly none or a short one, now and
	// then a long pause so that the request lands in every phase of the block.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 40);
		else
			return $urandom_range(60, 200);
	endfunction

	// Random operand pair. Uniform pairs mostly give a divisor of one, so
	// most of the mix is built from a shared factor, small values, equal
	// values, shifted values with factors of two and zero operands.
	function automatic gll_req_t random_pair();
		gll_req_t pair;
		int       kind;
		int       common;
		int       limit;
		kind = $urandom_range(0, 19);
		pair.first_number  = 16'($urandom);
		pair.second_number = 16'($urandom);
		case (kind)
			0: begin
				pair.first_number = 16'd0;
			end
			1: begin
				pair.second_number = 16'd0;
			end
			2, 3, 4, 5, 6: begin
				common = $urandom_range(2, 4000);
				limit  = 65535 / common;
				pair.first_number  = 16'(common * $urandom_range(1, limit));
				pair.second_number = 16'(common * $urandom_range(1, limit));
			end
			7, 8, 9: begin
				// Small operands keep the multiple near the 16-bit boundary.
				pair.first_number  = 16'($urandom_range(1, 600));
				pair.second_number = 16'($urandom_range(1, 600));
			end
			10: begin
				pair.second_number = pair.first_number;
			end
			11, 12: begin
				pair.first_number  = 16'(($urandom_range(1, 255)) << $urandom_range(0, 8));
				pair.second_number = 16'(($urandom_range(1, 255)) << $urandom_range(0, 8));
			end
			default: begin
			end
		endcase
		return pair;
	endfunction

	// One request transfer. Called at a falling edge; returns at the falling
	// edge after the transfer. With no gap, start simply stays high.
	task automatic send_pair(input gll_req_t pair, input int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) begin
				request = gll_req_t'($urandom);
				@(negedge clk);
			end
		end
		start   = 1'b1;
		request = pair;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		items_sent++;
	endtask

	// Hold off until the block has delivered every result it owes.
	task automatic drain_results();
		start = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	task automatic send_two(input logic [15:0] a, input logic [15:0] b);
		gll_req_t pair;
		pair.first_number  = a;
		pair.second_number = b;
		send_pair(pair, $urandom_range(0, 2));
	endtask

	initial begin
		int     failures;
		int     stretch;
		bit     no_idle;
		board      = new();
		items_sent = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pairs: zero operands, the extremes, the 16-bit boundary of
		// the multiple, equal and coprime operands, and powers of two.
		send_two(16'd0,     16'd0);
		send_two(16'd0,     16'd1234);
		send_two(16'd4321,  16'd0);
		send_two(16'd0,     16'hFFFF);
		send_two(16'hFFFF,  16'd0);
		send_two(16'd1,     16'd1);
		send_two(16'd1,     16'hFFFF);
		send_two(16'hFFFF,  16'd1);
		send_two(16'hFFFF,  16'hFFFF);
		send_two(16'hFFFF,  16'hFFFE);
		send_two(16'd65521, 16'd65519);
		send_two(16'h8000,  16'd2);
		send_two(16'h8000,  16'd3);
		send_two(16'h4000,  16'h8000);
		send_two(16'd255,   16'd257);
		send_two(16'd256,   16'd256);
		send_two(16'd12,    16'd18);
		send_two(16'd48,    16'd180);
		send_two(16'hAAAA,  16'h5555);
		send_two(16'hFF00,  16'h00FF);
		send_two(16'd3,     16'd21845);
		send_two(16'd7,     16'd9363);

		// Let the block empty out once, so the next request meets it idle.
		drain_results();

		// Random pairs, with stretches of back-to-back requests and an
		// occasional full drain in between.
		no_idle = 1'b0;
		stretch = 0;
		for (int n = 0; n < 1950; n++) begin
			if (stretch == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
				stretch = $urandom_range(20, 150);
			end
			stretch--;
			if ($urandom_range(0, 199) == 0)
				drain_results();
			send_pair(random_pair(), no_idle ? 0 : pick_gap());
		end
		start = 1'b0;

		drain_results();
		// Wait on after the drain, to catch a stray result that is still on its
		// way.
		repeat (150) @(posedge clk);

		failures = board.mismatch_count + board.stray_count + board.pending();
		$display("Sent %0d operand pairs, checked %0d results, %0d mismatches, %0d stray, %0d missing.",
			items_sent, board.results_checked, board.mismatch_count, board.stray_count,
			board.pending());
		$display("Pairs with a zero operand: %0d; multiples wider than 16 bits: %0d.",
			board.zero_pairs, board.wide_multiples);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
